>>> rtl/bnns_pkg.sv
// ============================================================================
// bnns_pkg
// Shared types, constants and the scale-to-ratio table of the sprite scaler.
// ============================================================================
`default_nettype none

package bnns_pkg;

    localparam int SpriteSide = 8;
    localparam int IdxW       = 3;
    localparam int ColW       = 8;
    localparam int ScaleW     = 4;
    localparam int RatioW     = 9;
    localparam int XW         = 6;
    localparam int PageW      = 3;

    localparam logic [ScaleW-1:0] ScaleReset = 4'd4;

    typedef enum logic {
        OpLoad = 1'b0,
        OpRead = 1'b1
    } t_opcode;

    // per-read mapping from output position to sprite coordinates
    typedef struct packed {
        logic                                 out_of_range;
        logic [IdxW-1:0]                      sx;
        logic [SpriteSide-1:0][IdxW-1:0]      sy;
    } t_coord;

    // (8 << 8) / (8 * s) + 1 for every reachable scale
    function automatic logic [RatioW-1:0] ratio_of(input logic [ScaleW-1:0] s);
        logic [RatioW-1:0] r;
        case (s)
            4'd1:    r = 9'd257;
            4'd2:    r = 9'd129;
            4'd3:    r = 9'd86;
            4'd4:    r = 9'd65;
            4'd5:    r = 9'd52;
            4'd6:    r = 9'd43;
            4'd7:    r = 9'd37;
            4'd8:    r = 9'd33;
            4'd9:    r = 9'd29;
            4'd10:   r = 9'd26;
            4'd11:   r = 9'd24;
            4'd12:   r = 9'd22;
            4'd13:   r = 9'd20;
            4'd14:   r = 9'd19;
            4'd15:   r = 9'd18;
            default: r = 9'd257;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/bnns_if.sv
// ============================================================================
// bnns_in_if / bnns_out_if
// Valid/ready channels carrying command words in and page-byte words out.
// ============================================================================
`default_nettype none

interface bnns_in_if;
    logic       valid;
    logic       ready;
    logic [0:0] opcode;
    logic [2:0] column_index;
    logic [7:0] column_bits;
    logic [5:0] out_column;
    logic [2:0] out_page;

    modport source (output valid, opcode, column_index, column_bits, out_column, out_page,
                    input ready);
    modport sink   (input valid, opcode, column_index, column_bits, out_column, out_page,
                    output ready);
endinterface

interface bnns_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] page_byte;
    logic       out_of_range;

    modport source (output valid, page_byte, out_of_range, input ready);
    modport sink   (input valid, page_byte, out_of_range, output ready);
endinterface

`default_nettype wire

>>> rtl/bnns_sprite_store.sv
// ============================================================================
// bnns_sprite_store
// Eight sprite column registers, one write port and one read port.
// ============================================================================
`default_nettype none

module bnns_sprite_store (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_we,
    input  wire logic [bnns_pkg::IdxW-1:0] i_waddr,
    input  wire logic [bnns_pkg::ColW-1:0] i_wdata,
    input  wire logic [bnns_pkg::IdxW-1:0] i_raddr,
    output logic      [bnns_pkg::ColW-1:0] o_rdata
);
    import bnns_pkg::*;

    logic [ColW-1:0] r_cols [SpriteSide];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SpriteSide; i++) begin
                r_cols[i] <= '0;
            end
        end else if (i_we) begin
            r_cols[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_cols[i_raddr];

endmodule

`default_nettype wire

>>> rtl/bnns_coord.sv
// ============================================================================
// bnns_coord
// Maps an output column and page to sprite column and row indexes.
// ============================================================================
`default_nettype none

module bnns_coord #(
    parameter int MAX_SCALE = 8
) (
    input  wire logic [bnns_pkg::ScaleW-1:0] i_scale,
    input  wire logic [bnns_pkg::XW-1:0]     i_x,
    input  wire logic [bnns_pkg::PageW-1:0]  i_page,
    output bnns_pkg::t_coord                 o_coord
);
    import bnns_pkg::*;

    localparam logic [ScaleW:0] MaxScaleW = (ScaleW+1)'(MAX_SCALE);

    logic [ScaleW:0]   scale_w;
    logic [ScaleW-1:0] eff;
    logic [ScaleW+2:0] side;
    logic [RatioW-1:0] ratio;
    logic [14:0]       xr;

    // clamp to 1..MAX_SCALE
    always_comb begin
        scale_w = {1'b0, i_scale};
        if (i_scale == '0) begin
            eff = ScaleW'(1);
        end else if (scale_w > MaxScaleW) begin
            eff = MaxScaleW[ScaleW-1:0];
        end else begin
            eff = i_scale;
        end
    end

    assign side  = {eff, 3'b000};
    assign ratio = ratio_of(eff);
    assign xr    = 15'(i_x) * 15'(ratio);

    always_comb begin
        logic [XW-1:0] y;
        logic [14:0]   yr;
        o_coord.out_of_range = ({1'b0, i_x} >= side) || ({1'b0, i_page} >= eff);
        o_coord.sx           = xr[10:8];
        for (int b = 0; b < SpriteSide; b++) begin
            y               = {i_page, 3'(b)};
            yr              = 15'(y) * 15'(ratio);
            o_coord.sy[b]   = yr[10:8];
        end
    end

endmodule

`default_nettype wire

>>> rtl/bitmap_nearest_neighbor_scaler_unit.sv
// ============================================================================
// bitmap_nearest_neighbor_scaler_unit
// Nearest-neighbor scaler for an 8x8 one-bit sprite, read as display pages.
// ============================================================================
// usage
//   i_in_ch  : command words; opcode load writes column_bits into sprite
//              column column_index, opcode read asks for the page byte at
//              out_column / out_page of the sprite scaled to 8*scale square
//   o_out_ch : one word per read: page_byte (bit b = row page*8+b) and
//              out_of_range (page_byte forced to zero when set)
//   i_cfg_we / i_cfg_wdata : scale register, write only while idle
// timing
//   one command word accepted per cycle while no read waits on a stalled result
//   a read passes through the input register, then the coordinate math and column
//   select fill the result register once it is free
//   loads retire from the input register in order, so a read always sees
//   every load accepted ahead of it
// reset
//   sprite cleared to zero, scale back to 4, both pipeline stages empty
// backpressure
//   a stalled result holds in the output register; the input register still
//   takes words, and ready drops only when a read waits behind it
// ============================================================================
`default_nettype none

module bitmap_nearest_neighbor_scaler_unit #(
    parameter int MAX_SCALE = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    bnns_in_if.sink                        i_in_ch,
    bnns_out_if.source                     o_out_ch,
    input  wire logic                      i_cfg_we,
    input  wire logic [bnns_pkg::ScaleW-1:0] i_cfg_wdata
);
    import bnns_pkg::*;

    // scale register
    logic [ScaleW-1:0] r_scale;

    // input stage
    logic              r_in_valid;
    t_opcode           r_in_op;
    logic [IdxW-1:0]   r_in_col_idx;
    logic [ColW-1:0]   r_in_col_bits;
    logic [XW-1:0]     r_in_x;
    logic [PageW-1:0]  r_in_page;

    // result stage
    logic              r_out_valid;
    logic [ColW-1:0]   r_out_byte;
    logic              r_out_oor;

    logic              in_accept;
    logic              is_load;
    logic              adv_read;
    logic              stage_free;
    t_coord            coord;
    logic [ColW-1:0]   col;
    logic [ColW-1:0]   n_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= ScaleReset;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    // stage handshake: loads always retire, reads need a free result slot
    assign is_load    = (r_in_op == OpLoad);
    assign adv_read   = r_in_valid && !is_load && (!r_out_valid || o_out_ch.ready);
    assign stage_free = !r_in_valid || is_load || adv_read;
    assign in_accept  = i_in_ch.valid && stage_free;

    assign i_in_ch.ready = stage_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (stage_free) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op       <= t_opcode'(i_in_ch.opcode);
            r_in_col_idx  <= i_in_ch.column_index;
            r_in_col_bits <= i_in_ch.column_bits;
            r_in_x        <= i_in_ch.out_column;
            r_in_page     <= i_in_ch.out_page;
        end
    end

    // sprite written when the load leaves the input stage
    bnns_sprite_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (r_in_valid && is_load),
        .i_waddr (r_in_col_idx),
        .i_wdata (r_in_col_bits),
        .i_raddr (coord.sx),
        .o_rdata (col)
    );

    bnns_coord #(
        .MAX_SCALE (MAX_SCALE)
    ) u_coord (
        .i_scale (r_scale),
        .i_x     (r_in_x),
        .i_page  (r_in_page),
        .o_coord (coord)
    );

    // pick each output row from the selected sprite column
    always_comb begin
        for (int b = 0; b < ColW; b++) begin
            n_byte[b] = col[coord.sy[b]] && !coord.out_of_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_read) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_read) begin
            r_out_byte <= n_byte;
            r_out_oor  <= coord.out_of_range;
        end
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.page_byte    = r_out_byte;
    assign o_out_ch.out_of_range = r_out_oor;

endmodule

`default_nettype wire

>>> rtl/bnns_checker.sv
// ============================================================================
// bnns_checker
// Port-level checks on the result channel of the sprite scaler.
// ============================================================================
`default_nettype none

module bnns_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_page_byte,
    input wire logic       i_out_of_range
);

    // stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_page_byte) && $stable(i_out_of_range))
        else $error("result word changed while stalled");

    // positions outside the square carry no pixels
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_of_range |-> i_page_byte == 8'h00)
        else $error("out-of-range word has pixels set");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind bitmap_nearest_neighbor_scaler_unit bnns_checker u_bnns_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out_ch.valid),
    .i_out_ready    (o_out_ch.ready),
    .i_page_byte    (o_out_ch.page_byte),
    .i_out_of_range (o_out_ch.out_of_range)
);

`default_nettype wire
